// File: src/bic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bic_pkg: shared types and constants of the block bit inversion codec
// Field widths, block size limits, rule codes and register indexes.
// ----------------------------------------------------------------------------
package bic_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int SIZE_W    = 7;   // holds 0..127 as written, 1..MAX_BLOCK in use
  localparam int POS_W     = 6;   // position inside a block, 0..MAX_BLOCK-1
  localparam int CNT_W     = 7;   // zero or one count, 0..MAX_BLOCK
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  typedef logic [DATA_W-1:0] byte_t;

  typedef enum logic [1:0] {
    RULE_ALL   = 2'd0,   // invert every bit
    RULE_ODD   = 2'd1,   // invert bits at odd positions
    RULE_THIRD = 2'd2    // invert bits at positions 2, 5, 8, ...
  } rule_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 2'd0,
    REG_DIRECTION  = 2'd1
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(4);
  localparam logic              DIRECTION_RST  = 1'b1;
  localparam logic              DIR_DECODE     = 1'b1;

endpackage

`default_nettype wire

// File: src/bic_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bic_if: word channels of the block bit inversion codec
// Input channel carries source bytes, output channel carries encoded or decoded bytes.
// ----------------------------------------------------------------------------
interface bic_in_if
  import bic_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bic_out_if
  import bic_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// File: src/block_bit_inversion_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_bit_inversion_codec: per-block bit inversion encoder and decoder
// Codes a byte stream MSB first in blocks, the rule of each block chosen by
// the zero and one counts of the block before it.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Payload
//  in_ch     in   valid / ready    data_byte[7:0], last_byte
//  out_ch    out  valid / ready    out_byte[7:0], out_last
//  cfg_*     in   cfg_we           cfg_index[1:0], cfg_data[6:0]
//
//  The eight bit steps of the inversion rule run in one combinational pass
//  from the block state registers to the output register, so one word is
//  accepted and one result produced every cycle unless the output stalls.
//  Output valid is registered and rises in the cycle after input acceptance.
//  Reset clears block state and output valid and loads the register defaults.
//  A stalled output word holds; input is taken whenever the output register
//  is empty or is being emptied in the same cycle.
// ----------------------------------------------------------------------------
module block_bit_inversion_codec
  import bic_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bic_in_if.sink                    in_ch,
  bic_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] block_size_r;
  logic              direction_r;

  rule_t             rule_r,  rule_nxt;
  logic [POS_W-1:0]  pos_r,   pos_nxt;
  logic [1:0]        mod3_r,  mod3_nxt;
  logic [CNT_W-1:0]  zc_r,    zc_nxt;
  logic [CNT_W-1:0]  oc_r,    oc_nxt;

  logic              out_valid_r;
  byte_t             out_byte_r, out_byte_nxt;
  logic              out_last_r;

  logic              accept;
  logic [SIZE_W-1:0] size_eff;

  assign in_ch.ready     = !out_valid_r || out_ch.ready;
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  // Out-of-range block sizes are clamped to 1..MAX_BLOCK.
  always_comb begin
    if (block_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (block_size_r > SIZE_W'(MAX_BLOCK)) begin
      size_eff = SIZE_W'(MAX_BLOCK);
    end else begin
      size_eff = block_size_r;
    end
  end

  // Eight chained bit steps, MSB first.
  always_comb begin
    rule_t             rule_v;
    logic [SIZE_W-1:0] pos_v;
    logic [1:0]        mod3_v;
    logic [CNT_W-1:0]  zc_v;
    logic [CNT_W-1:0]  oc_v;
    logic              b;
    logic              flip;
    logic              o;
    logic              plain;

    rule_v       = rule_r;
    pos_v        = {1'b0, pos_r};
    mod3_v       = mod3_r;
    zc_v         = zc_r;
    oc_v         = oc_r;
    out_byte_nxt = '0;

    for (int k = DATA_W - 1; k >= 0; k--) begin
      b = in_ch.data_byte[k];
      unique case (rule_v)
        RULE_ALL:   flip = 1'b1;
        RULE_ODD:   flip = pos_v[0];
        RULE_THIRD: flip = (mod3_v == 2'd2);
        default:    flip = (mod3_v == 2'd2);
      endcase
      o               = b ^ flip;
      out_byte_nxt[k] = o;
      plain           = (direction_r == DIR_DECODE) ? o : b;
      if (plain) begin
        oc_v = oc_v + CNT_W'(1);
      end else begin
        zc_v = zc_v + CNT_W'(1);
      end
      pos_v  = pos_v + SIZE_W'(1);
      mod3_v = (mod3_v == 2'd2) ? 2'd0 : mod3_v + 2'd1;

      if (pos_v >= size_eff) begin
        if (zc_v > oc_v) begin
          rule_v = RULE_ODD;
        end else if (zc_v < oc_v) begin
          rule_v = RULE_THIRD;
        end else begin
          rule_v = RULE_ALL;
        end
        pos_v  = '0;
        mod3_v = 2'd0;
        zc_v   = '0;
        oc_v   = '0;
      end
    end

    // The position stays below the block size, so it fits POS_W bits.
    rule_nxt = rule_v;
    pos_nxt  = pos_v[POS_W-1:0];
    mod3_nxt = mod3_v;
    zc_nxt   = zc_v;
    oc_nxt   = oc_v;

    // The last word of a message returns the block state to its start.
    if (in_ch.last_byte) begin
      rule_nxt = RULE_ALL;
      pos_nxt  = '0;
      mod3_nxt = 2'd0;
      zc_nxt   = '0;
      oc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      direction_r  <= DIRECTION_RST;
      rule_r       <= RULE_ALL;
      pos_r        <= '0;
      mod3_r       <= 2'd0;
      zc_r         <= '0;
      oc_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BLOCK_SIZE: block_size_r <= cfg_data[SIZE_W-1:0];
          REG_DIRECTION:  direction_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        rule_r      <= rule_nxt;
        pos_r       <= pos_nxt;
        mod3_r      <= mod3_nxt;
        zc_r        <= zc_nxt;
        oc_r        <= oc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= in_ch.last_byte;
    end
  end

endmodule

`default_nettype wire
